// ----- design/mre_pkg.sv -----
package mre_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_REPORTING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y         = 3'd5;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_X10 = 2'd1;
  localparam logic [1:0] MODE_SGR = 2'd2;

  localparam logic [1:0] REQ_MOTION = 2'd0;
  localparam logic [1:0] REQ_DOWN   = 2'd1;
  localparam logic [1:0] REQ_UP     = 2'd2;

  localparam logic [8:0] GRID_COLS_RST = 9'd80;
  localparam logic [7:0] GRID_ROWS_RST = 8'd24;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [1:0] report_mode;
    logic       motion_reporting;
    logic [8:0] grid_cols;
    logic [7:0] grid_rows;
    logic [3:0] offset_x;
    logic [4:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic [3:0] t;
    logic [3:0] o;
  } dig2_t;

  typedef struct packed {
    logic [2:0] h;
    logic [3:0] t;
    logic [3:0] o;
  } dec_t;

  typedef struct packed {
    logic       sgr;
    logic       up;
    logic [6:0] code;
    logic [8:0] col;
    logic [7:0] row;
    dec_t       col_dec;
    dec_t       row_dec;
  } rep_t;

  function automatic dig2_t split_tens(input logic [6:0] v);
    dig2_t      d;
    logic [6:0] tv;
    d.t = '0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(10 * k)) begin
        d.t = 4'(k);
      end
    end
    tv  = 7'({d.t, 3'b000}) + 7'({d.t, 1'b0});
    d.o = 4'(v - tv);
    return d;
  endfunction

endpackage

// ----- design/mre_front.sv -----
module mre_front #(
  parameter int CELL_W = 8,
  parameter int CELL_H = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mre_pkg::cfg_t       cfg,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          req_type,
  input  logic [2:0]          button_number,
  input  logic [11:0]         pixel_x,
  input  logic [11:0]         pixel_y,
  output logic                q_push,
  input  logic                q_full,
  output mre_pkg::rep_t       q_data
);

  localparam logic [24:0] RECIP_X = 25'((32'd1 << 24) / CELL_W);
  localparam logic [24:0] RECIP_Y = 25'((32'd1 << 24) / CELL_H);

  localparam logic [2:0] BTN_MIDDLE     = 3'd2;
  localparam logic [2:0] BTN_RIGHT      = 3'd3;
  localparam logic [2:0] BTN_WHEEL_UP   = 3'd4;
  localparam logic [2:0] BTN_WHEEL_DOWN = 3'd5;

  localparam logic [6:0] CODE_LEFT       = 7'd0;
  localparam logic [6:0] CODE_MIDDLE     = 7'd1;
  localparam logic [6:0] CODE_RIGHT      = 7'd2;
  localparam logic [6:0] CODE_WHEEL_UP   = 7'd64;
  localparam logic [6:0] CODE_WHEEL_DOWN = 7'd65;
  localparam logic [6:0] CODE_MOTION     = 7'd32;

  typedef struct packed {
    logic [2:0] h;
    logic [6:0] rem;
  } hund_t;

  function automatic hund_t split_hund(input logic [9:0] v);
    hund_t      r;
    logic [9:0] sub;
    r.h = '0;
    sub = '0;
    for (int k = 1; k < 6; k++) begin
      if (v >= 10'(100 * k)) begin
        r.h = 3'(k);
        sub = 10'(100 * k);
      end
    end
    r.rem = 7'(v - sub);
    return r;
  endfunction

  function automatic logic [6:0] button_code(input logic [2:0] b);
    logic [6:0] c;
    case (b)
      BTN_MIDDLE:     c = CODE_MIDDLE;
      BTN_RIGHT:      c = CODE_RIGHT;
      BTN_WHEEL_UP:   c = CODE_WHEEL_UP;
      BTN_WHEEL_DOWN: c = CODE_WHEEL_DOWN;
      default:        c = CODE_LEFT;
    endcase
    return c;
  endfunction

  logic        s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [1:0]  s1_req_r, s2_req_r, s3_req_r, s4_req_r;
  logic [2:0]  s1_btn_r, s2_btn_r, s3_btn_r, s4_btn_r;
  logic [11:0] s1_dx_r, s1_dy_r, s2_dx_r, s2_dy_r;
  logic [11:0] s2_qx_r, s2_qy_r;
  logic [8:0]  s3_col_r, s4_col_r;
  logic [7:0]  s3_row_r, s4_row_r;
  hund_t       s4_chd_r, s4_rhd_r;

  logic [2:0]  held_r, held_nxt;
  logic [8:0]  last_col_r, last_col_nxt;
  logic [7:0]  last_row_r, last_row_nxt;
  logic        lpv_r, lpv_nxt;

  logic        adv, fire, emit;
  logic [11:0] dx_nxt, dy_nxt;
  logic [36:0] px_prod, py_prod;
  logic [16:0] cx_prod, cy_prod, rx, ry;
  logic [12:0] qx, qy;
  logic [8:0]  col_nxt;
  logic [7:0]  row_nxt;
  logic        motion, down, up, same, active_motion, report_ok, mode_ok;
  logic [2:0]  btn_eff;
  logic [6:0]  code;
  mre_pkg::dig2_t col_lo, row_lo;

  assign dx_nxt = (pixel_x >= 12'(cfg.offset_x)) ? pixel_x - 12'(cfg.offset_x) : '0;
  assign dy_nxt = (pixel_y >= 12'(cfg.offset_y)) ? pixel_y - 12'(cfg.offset_y) : '0;

  assign px_prod = 37'(s1_dx_r) * 37'(RECIP_X);
  assign py_prod = 37'(s1_dy_r) * 37'(RECIP_Y);

  assign cx_prod = 17'(s2_qx_r) * 17'(CELL_W);
  assign cy_prod = 17'(s2_qy_r) * 17'(CELL_H);
  assign rx      = 17'(s2_dx_r) - cx_prod;
  assign ry      = 17'(s2_dy_r) - cy_prod;
  assign qx      = 13'(s2_qx_r) + 13'(rx >= 17'(CELL_W));
  assign qy      = 13'(s2_qy_r) + 13'(ry >= 17'(CELL_H));
  assign col_nxt = (qx > 13'(cfg.grid_cols)) ? cfg.grid_cols : qx[8:0];
  assign row_nxt = (qy > 13'(cfg.grid_rows)) ? cfg.grid_rows : qy[7:0];

  assign motion  = (s4_req_r == mre_pkg::REQ_MOTION);
  assign down    = (s4_req_r == mre_pkg::REQ_DOWN);
  assign up      = (s4_req_r == mre_pkg::REQ_UP);
  assign btn_eff = motion ? held_r : s4_btn_r;
  assign code    = button_code(btn_eff) + (motion ? CODE_MOTION : 7'd0);
  assign same    = lpv_r && (s4_col_r == last_col_r) && (s4_row_r == last_row_r);
  assign active_motion = motion && (held_r != 3'd0) && !same;
  assign report_ok = motion ? (active_motion && cfg.motion_reporting) : 1'b1;

  always_comb begin
    case (cfg.report_mode)
      mre_pkg::MODE_X10: mode_ok = down || motion;
      mre_pkg::MODE_SGR: mode_ok = down || up || motion;
      default:           mode_ok = 1'b0;
    endcase
  end

  assign emit = report_ok && mode_ok;
  assign fire = s4_v_r && (!emit || !q_full);
  assign adv  = !s4_v_r || fire;
  assign full = !adv;

  assign q_push = fire && emit;
  assign col_lo = mre_pkg::split_tens(s4_chd_r.rem);
  assign row_lo = mre_pkg::split_tens(s4_rhd_r.rem);

  always_comb begin
    q_data.sgr       = (cfg.report_mode == mre_pkg::MODE_SGR);
    q_data.up        = up;
    q_data.code      = code;
    q_data.col       = s4_col_r;
    q_data.row       = s4_row_r;
    q_data.col_dec.h = s4_chd_r.h;
    q_data.col_dec.t = col_lo.t;
    q_data.col_dec.o = col_lo.o;
    q_data.row_dec.h = s4_rhd_r.h;
    q_data.row_dec.t = row_lo.t;
    q_data.row_dec.o = row_lo.o;
  end

  always_comb begin
    held_nxt     = held_r;
    last_col_nxt = last_col_r;
    last_row_nxt = last_row_r;
    lpv_nxt      = lpv_r;
    if (fire) begin
      if (motion) begin
        if (active_motion) begin
          last_col_nxt = s4_col_r;
          last_row_nxt = s4_row_r;
          lpv_nxt      = 1'b1;
        end
      end else if (down) begin
        if (held_r == 3'd0) begin
          held_nxt = s4_btn_r;
        end
        lpv_nxt = 1'b0;
      end else begin
        held_nxt = '0;
        lpv_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      s4_v_r     <= 1'b0;
      held_r     <= '0;
      last_col_r <= '0;
      last_row_r <= '0;
      lpv_r      <= 1'b0;
    end else begin
      if (adv) begin
        s1_v_r <= push;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
        s4_v_r <= s3_v_r;
      end
      held_r     <= held_nxt;
      last_col_r <= last_col_nxt;
      last_row_r <= last_row_nxt;
      lpv_r      <= lpv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req_r <= req_type;
      s1_btn_r <= button_number;
      s1_dx_r  <= dx_nxt;
      s1_dy_r  <= dy_nxt;
      s2_req_r <= s1_req_r;
      s2_btn_r <= s1_btn_r;
      s2_dx_r  <= s1_dx_r;
      s2_dy_r  <= s1_dy_r;
      s2_qx_r  <= px_prod[35:24];
      s2_qy_r  <= py_prod[35:24];
      s3_req_r <= s2_req_r;
      s3_btn_r <= s2_btn_r;
      s3_col_r <= col_nxt;
      s3_row_r <= row_nxt;
      s4_req_r <= s3_req_r;
      s4_btn_r <= s3_btn_r;
      s4_col_r <= s3_col_r;
      s4_row_r <= s3_row_r;
      s4_chd_r <= split_hund(10'(s3_col_r) + 10'd1);
      s4_rhd_r <= split_hund(10'(s3_row_r) + 10'd1);
    end
  end

endmodule

// ----- design/mre_fifo.sv -----
module mre_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  mre_pkg::rep_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output mre_pkg::rep_t rd_data,
  output logic          empty
);

  mre_pkg::rep_t                  mem_r [mre_pkg::QDEPTH];
  logic [mre_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [mre_pkg::QPTR_W:0]       count_r;
  logic                           wr, rd;

  assign full    = (count_r == (mre_pkg::QPTR_W + 1)'(mre_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign wr      = wr_en && !full;
  assign rd      = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr && !rd) begin
        count_r <= count_r + 1'b1;
      end else if (rd && !wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- design/mre_back.sv -----
module mre_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  mre_pkg::rep_t q_data,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    report_byte,
  output logic          last_byte
);

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_UPPER_M = 8'h4D;
  localparam logic [7:0] CH_LOWER_M = 8'h6D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] X10_CODE_BIAS = 8'd32;
  localparam logic [7:0] X10_POS_BIAS  = 8'd33;

  typedef enum logic [13:0] {
    ST_ESC   = 14'b00000000000001,
    ST_BRK   = 14'b00000000000010,
    ST_LEAD  = 14'b00000000000100,
    ST_CODE_T = 14'b00000000001000,
    ST_CODE_O = 14'b00000000010000,
    ST_SEP1  = 14'b00000000100000,
    ST_COL_H = 14'b00000001000000,
    ST_COL_T = 14'b00000010000000,
    ST_COL_O = 14'b00000100000000,
    ST_SEP2  = 14'b00001000000000,
    ST_ROW_H = 14'b00010000000000,
    ST_ROW_T = 14'b00100000000000,
    ST_ROW_O = 14'b01000000000000,
    ST_TERM  = 14'b10000000000000
  } step_t;

  step_t          step_r, step_nxt;
  mre_pkg::rep_t  cur_r;
  mre_pkg::dig2_t code_dig_r;
  logic           cur_v_r;
  logic           out_v_r;
  logic [7:0]     out_byte_r;
  logic           out_last_r;

  logic           produce, load, out_take;
  logic [7:0]     byte_nxt;
  logic           last_nxt;

  assign out_take    = pop && out_v_r;
  assign produce     = cur_v_r && (!out_v_r || out_take);
  assign load        = !q_empty && (!cur_v_r || (produce && last_nxt));
  assign q_pop       = load;
  assign empty       = !out_v_r;
  assign report_byte = out_byte_r;
  assign last_byte   = out_last_r;

  always_comb begin
    byte_nxt = CH_ESC;
    last_nxt = 1'b0;
    step_nxt = step_r;
    case (step_r)
      ST_ESC: begin
        byte_nxt = CH_ESC;
        step_nxt = ST_BRK;
      end
      ST_BRK: begin
        byte_nxt = CH_LBRACK;
        step_nxt = ST_LEAD;
      end
      ST_LEAD: begin
        byte_nxt = cur_r.sgr ? CH_LT : CH_UPPER_M;
        step_nxt = (cur_r.sgr && code_dig_r.t != 4'd0) ? ST_CODE_T : ST_CODE_O;
      end
      ST_CODE_T: begin
        byte_nxt = CH_ZERO + 8'(code_dig_r.t);
        step_nxt = ST_CODE_O;
      end
      ST_CODE_O: begin
        byte_nxt = cur_r.sgr ? CH_ZERO + 8'(code_dig_r.o) : 8'(cur_r.code) + X10_CODE_BIAS;
        step_nxt = cur_r.sgr ? ST_SEP1 : ST_COL_O;
      end
      ST_SEP1: begin
        byte_nxt = CH_SEMI;
        if (cur_r.col_dec.h != 3'd0) begin
          step_nxt = ST_COL_H;
        end else if (cur_r.col_dec.t != 4'd0) begin
          step_nxt = ST_COL_T;
        end else begin
          step_nxt = ST_COL_O;
        end
      end
      ST_COL_H: begin
        byte_nxt = CH_ZERO + 8'(cur_r.col_dec.h);
        step_nxt = ST_COL_T;
      end
      ST_COL_T: begin
        byte_nxt = CH_ZERO + 8'(cur_r.col_dec.t);
        step_nxt = ST_COL_O;
      end
      ST_COL_O: begin
        byte_nxt = cur_r.sgr ? CH_ZERO + 8'(cur_r.col_dec.o) : cur_r.col[7:0] + X10_POS_BIAS;
        step_nxt = cur_r.sgr ? ST_SEP2 : ST_ROW_O;
      end
      ST_SEP2: begin
        byte_nxt = CH_SEMI;
        if (cur_r.row_dec.h != 3'd0) begin
          step_nxt = ST_ROW_H;
        end else if (cur_r.row_dec.t != 4'd0) begin
          step_nxt = ST_ROW_T;
        end else begin
          step_nxt = ST_ROW_O;
        end
      end
      ST_ROW_H: begin
        byte_nxt = CH_ZERO + 8'(cur_r.row_dec.h);
        step_nxt = ST_ROW_T;
      end
      ST_ROW_T: begin
        byte_nxt = CH_ZERO + 8'(cur_r.row_dec.t);
        step_nxt = ST_ROW_O;
      end
      ST_ROW_O: begin
        byte_nxt = cur_r.sgr ? CH_ZERO + 8'(cur_r.row_dec.o) : cur_r.row + X10_POS_BIAS;
        last_nxt = !cur_r.sgr;
        step_nxt = cur_r.sgr ? ST_TERM : ST_ESC;
      end
      ST_TERM: begin
        byte_nxt = cur_r.up ? CH_LOWER_M : CH_UPPER_M;
        last_nxt = 1'b1;
        step_nxt = ST_ESC;
      end
      default: begin
        byte_nxt = CH_ESC;
        step_nxt = ST_ESC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_ESC;
      cur_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (load) begin
        step_r <= ST_ESC;
      end else if (produce) begin
        step_r <= step_nxt;
      end
      if (load) begin
        cur_v_r <= 1'b1;
      end else if (produce && last_nxt) begin
        cur_v_r <= 1'b0;
      end
      if (produce) begin
        out_v_r <= 1'b1;
      end else if (out_take) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r      <= q_data;
      code_dig_r <= mre_pkg::split_tens(q_data.code);
    end
    if (produce) begin
      out_byte_r <= byte_nxt;
      out_last_r <= last_nxt;
    end
  end

endmodule

// ----- design/mouse_report_encoder_unit.sv -----
// Mouse report encoder. Mouse events enter on the input queue port: an event
// transfers on a clock edge with push high and full low. Report bytes leave on
// the output queue port: the oldest byte is shown while empty is low and
// transfers on an edge with pop high. The final byte of each report has
// out_last_byte set. The user must write the registers through cfg_write_en,
// cfg_index and cfg_wdata only while no event is in flight; the block does not
// enforce this. A four-stage front pipeline computes the cell and decides
// whether to report; it takes one event per cycle until the four-entry report
// queue fills. The back end sends one byte per cycle while the receiver pops:
// six bytes for an X10 report and 9 to 14 for an SGR report, so reporting
// events are paced by the back end; events that give no report never enter
// the queue. An event reaches the output via the stages, the queue and cur_r.
// When the receiver stalls, the output register holds its byte, the queue
// fills and full rises. Reset empties all stages and the queue, forgets the
// held button and the last cell, and loads the register reset values.
module mouse_report_encoder_unit #(
  parameter int CELL_W = 8,
  parameter int CELL_H = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      in_req_type,
  input  logic [2:0]                      in_button_number,
  input  logic [11:0]                     in_pixel_x,
  input  logic [11:0]                     in_pixel_y,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      out_report_byte,
  output logic                            out_last_byte,
  input  logic                            cfg_write_en,
  input  logic [mre_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mre_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  mre_pkg::cfg_t cfg_r;
  mre_pkg::rep_t fq_data, qb_data;
  logic          fq_push, fq_full, qb_pop, qb_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.report_mode      <= mre_pkg::MODE_OFF;
      cfg_r.motion_reporting <= 1'b0;
      cfg_r.grid_cols        <= mre_pkg::GRID_COLS_RST;
      cfg_r.grid_rows        <= mre_pkg::GRID_ROWS_RST;
      cfg_r.offset_x         <= '0;
      cfg_r.offset_y         <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        mre_pkg::CFG_REPORT_MODE:      cfg_r.report_mode      <= cfg_wdata[1:0];
        mre_pkg::CFG_MOTION_REPORTING: cfg_r.motion_reporting <= cfg_wdata[0];
        mre_pkg::CFG_GRID_COLS:        cfg_r.grid_cols        <= cfg_wdata[8:0];
        mre_pkg::CFG_GRID_ROWS:        cfg_r.grid_rows        <= cfg_wdata[7:0];
        mre_pkg::CFG_OFFSET_X:         cfg_r.offset_x         <= cfg_wdata[3:0];
        mre_pkg::CFG_OFFSET_Y:         cfg_r.offset_y         <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  mre_front #(
    .CELL_W (CELL_W),
    .CELL_H (CELL_H)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .push          (push),
    .full          (full),
    .req_type      (in_req_type),
    .button_number (in_button_number),
    .pixel_x       (in_pixel_x),
    .pixel_y       (in_pixel_y),
    .q_push        (fq_push),
    .q_full        (fq_full),
    .q_data        (fq_data)
  );

  mre_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_data (fq_data),
    .full    (fq_full),
    .rd_en   (qb_pop),
    .rd_data (qb_data),
    .empty   (qb_empty)
  );

  mre_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (qb_empty),
    .q_data      (qb_data),
    .q_pop       (qb_pop),
    .empty       (empty),
    .pop         (pop),
    .report_byte (out_report_byte),
    .last_byte   (out_last_byte)
  );

endmodule

// ----- tb/sv/mouse_report_encoder_unit_test.sv -----
`timescale 1ns / 100ps

module mouse_report_encoder_unit_test;

  localparam int CELL_W = 8;
  localparam int CELL_H = 16;
  localparam int PIX_MAX = 4095;
  localparam int DRAIN_CYCLES = 24;
  localparam int ITEMS_PER_SEGMENT = 40;
  localparam int SEGMENTS = 8;

  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [2:0] BTN_NONE       = 3'd0;
  localparam logic [2:0] BTN_LEFT       = 3'd1;
  localparam logic [2:0] BTN_MIDDLE     = 3'd2;
  localparam logic [2:0] BTN_RIGHT      = 3'd3;
  localparam logic [2:0] BTN_WHEEL_UP   = 3'd4;
  localparam logic [2:0] BTN_WHEEL_DOWN = 3'd5;
  localparam logic [2:0] BTN_BOGUS_6    = 3'd6;
  localparam logic [2:0] BTN_BOGUS_7    = 3'd7;

  localparam int unsigned XT_LEFT       = 0;
  localparam int unsigned XT_MIDDLE     = 1;
  localparam int unsigned XT_RIGHT      = 2;
  localparam int unsigned XT_WHEEL_UP   = 64;
  localparam int unsigned XT_WHEEL_DOWN = 65;
  localparam int unsigned XT_DRAG       = 32;
  localparam int unsigned X10_CODE_BIAS = 32;
  localparam int unsigned X10_CELL_BIAS = 33;

  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LBRACK  = "[";
  localparam logic [7:0] CH_UPPER_M = "M";
  localparam logic [7:0] CH_LOWER_M = "m";

  typedef struct {
    logic [1:0]  req;
    logic [2:0]  btn;
    logic [11:0] px;
    logic [11:0] py;
  } mouse_event_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } report_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] in_req_type = mre_pkg::REQ_MOTION;
  logic [2:0] in_button_number = BTN_NONE;
  logic [11:0] in_pixel_x = '0;
  logic [11:0] in_pixel_y = '0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] out_report_byte;
  logic out_last_byte;
  logic cfg_write_en = 1'b0;
  logic [mre_pkg::CFG_IDX_W-1:0] cfg_index = mre_pkg::CFG_REPORT_MODE;
  logic [mre_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  mouse_event_t pending_events[$];
  report_byte_t report_bytes_due[$];

  mre_pkg::cfg_t shadow_cfg;
  logic [2:0] held_btn;
  int unsigned last_cell_col;
  int unsigned last_cell_row;
  bit last_cell_valid;

  bit in_accepted = 1'b0;
  bit hold_input = 1'b0;
  int send_gap_pct = 0;
  int pop_stall_pct = 0;

  int errors = 0;
  int queued_total = 0;
  int events_in = 0;
  int bytes_checked = 0;
  int reports_checked = 0;
  int reg_writes = 0;

  mouse_report_encoder_unit #(
    .CELL_W(CELL_W),
    .CELL_H(CELL_H)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_req_type(in_req_type),
    .in_button_number(in_button_number),
    .in_pixel_x(in_pixel_x),
    .in_pixel_y(in_pixel_y),
    .empty(empty),
    .pop(pop),
    .out_report_byte(out_report_byte),
    .out_last_byte(out_last_byte),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic void flag_error(input string what);
    errors++;
    if (errors <= 10) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
  endfunction

  function automatic int unsigned xterm_code(input logic [2:0] btn);
    case (btn)
      BTN_MIDDLE:     return XT_MIDDLE;
      BTN_RIGHT:      return XT_RIGHT;
      BTN_WHEEL_UP:   return XT_WHEEL_UP;
      BTN_WHEEL_DOWN: return XT_WHEEL_DOWN;
      default:        return XT_LEFT;
    endcase
  endfunction

  function automatic int unsigned cell_of(input int unsigned pix, input int unsigned off,
                                          input int unsigned size, input int unsigned lim);
    int unsigned c;
    c = (pix >= off) ? (pix - off) / size : 0;
    return (c > lim) ? lim : c;
  endfunction

  // Updates the pointer state for one event and queues the report bytes it produces.
  function automatic void encode_event(input mouse_event_t ev);
    logic [2:0] btn;
    int unsigned code;
    int unsigned col;
    int unsigned row;
    bit is_motion;
    bit is_down;
    bit is_up;
    logic [7:0] seq[$];
    string txt;
    report_byte_t rb;
    btn = ev.btn;
    is_motion = (ev.req == mre_pkg::REQ_MOTION);
    is_down = (ev.req == mre_pkg::REQ_DOWN);
    is_up = (ev.req == mre_pkg::REQ_UP);
    if (is_motion) begin
      if (held_btn == BTN_NONE) return;
      btn = held_btn;
    end else if (is_down) begin
      if (held_btn == BTN_NONE) held_btn = ev.btn;
      last_cell_valid = 1'b0;
    end else begin
      held_btn = BTN_NONE;
      last_cell_valid = 1'b0;
    end
    code = xterm_code(btn);
    col = cell_of(ev.px, shadow_cfg.offset_x, CELL_W, shadow_cfg.grid_cols);
    row = cell_of(ev.py, shadow_cfg.offset_y, CELL_H, shadow_cfg.grid_rows);
    if (is_motion) begin
      if (last_cell_valid && col == last_cell_col && row == last_cell_row) return;
      last_cell_col = col;
      last_cell_row = row;
      last_cell_valid = 1'b1;
      if (!shadow_cfg.motion_reporting) return;
      code += XT_DRAG;
    end
    if (shadow_cfg.report_mode == mre_pkg::MODE_X10) begin
      if (!(is_down || is_motion)) return;
      seq = '{CH_ESC, CH_LBRACK, CH_UPPER_M, 8'(code + X10_CODE_BIAS),
              8'(col + X10_CELL_BIAS), 8'(row + X10_CELL_BIAS)};
    end else if (shadow_cfg.report_mode == mre_pkg::MODE_SGR) begin
      if (!(is_down || is_up || is_motion)) return;
      txt = $sformatf("<%0d;%0d;%0d", code, col + 1, row + 1);
      seq = '{CH_ESC, CH_LBRACK};
      for (int i = 0; i < txt.len(); i++) seq.push_back(txt[i]);
      seq.push_back(is_up ? CH_LOWER_M : CH_UPPER_M);
    end else begin
      return;
    end
    for (int i = 0; i < seq.size(); i++) begin
      rb.data = seq[i];
      rb.last = (i == seq.size() - 1);
      report_bytes_due.push_back(rb);
    end
  endfunction

  function automatic void queue_event(input logic [1:0] req, input logic [2:0] btn,
                                      input int unsigned x, input int unsigned y);
    mouse_event_t ev;
    ev.req = req;
    ev.btn = btn;
    ev.px = 12'(x);
    ev.py = 12'(y);
    pending_events.push_back(ev);
    queued_total++;
  endfunction

  function automatic int unsigned pick_pixel(input int unsigned span);
    if ($urandom_range(9) < 8) return $urandom_range((span > PIX_MAX) ? PIX_MAX : span);
    return $urandom_range(PIX_MAX);
  endfunction

  function automatic int unsigned pick_x();
    return pick_pixel(int'(shadow_cfg.grid_cols) * CELL_W + int'(shadow_cfg.offset_x) + CELL_W);
  endfunction

  function automatic int unsigned pick_y();
    return pick_pixel(int'(shadow_cfg.grid_rows) * CELL_H + int'(shadow_cfg.offset_y) + CELL_H);
  endfunction

  function automatic int unsigned nudge(input int unsigned v);
    int t;
    t = int'(v) + int'($urandom_range(8)) - 4;
    if (t < 0) t = 0;
    if (t > PIX_MAX) t = PIX_MAX;
    return t;
  endfunction

  // Mostly press, drag and release with random content; the rest is noise.
  function automatic void gen_gesture();
    logic [2:0] btn;
    int unsigned x;
    int unsigned y;
    int unsigned steps;
    if ($urandom_range(99) < 75) begin
      btn = 3'($urandom_range(BTN_WHEEL_DOWN, BTN_LEFT));
      x = pick_x();
      y = pick_y();
      queue_event(mre_pkg::REQ_DOWN, btn, x, y);
      steps = $urandom_range(6);
      for (int i = 0; i < steps; i++) begin
        case ($urandom_range(3))
          0: ;
          1: begin
            x = nudge(x);
            y = nudge(y);
          end
          default: begin
            x = pick_x();
            y = pick_y();
          end
        endcase
        queue_event(mre_pkg::REQ_MOTION, 3'($urandom), x, y);
      end
      if ($urandom_range(9) == 0) begin
        queue_event(mre_pkg::REQ_DOWN, 3'($urandom), pick_x(), pick_y());
      end
      queue_event(mre_pkg::REQ_UP, btn, x, y);
    end else begin
      queue_event(2'($urandom), 3'($urandom), $urandom_range(PIX_MAX), $urandom_range(PIX_MAX));
    end
  endfunction

  always @(posedge clk) begin
    report_byte_t due;
    in_accepted = rst_n && push && !full;
    if (!rst_n) begin
      shadow_cfg = '{mre_pkg::MODE_OFF, 1'b0, mre_pkg::GRID_COLS_RST,
                     mre_pkg::GRID_ROWS_RST, 4'd0, 5'd0};
      held_btn = BTN_NONE;
      last_cell_col = 0;
      last_cell_row = 0;
      last_cell_valid = 1'b0;
    end else begin
      if (pop && !empty) begin
        if (report_bytes_due.size() == 0) begin
          flag_error($sformatf("unexpected byte %h last %b", out_report_byte, out_last_byte));
        end else begin
          due = report_bytes_due.pop_front();
          if (out_report_byte !== due.data || out_last_byte !== due.last) begin
            flag_error($sformatf("byte %h last %b, expected byte %h last %b",
                                 out_report_byte, out_last_byte, due.data, due.last));
          end
        end
        bytes_checked++;
        if (out_last_byte === 1'b1) reports_checked++;
      end
      if (cfg_write_en) begin
        case (cfg_index)
          mre_pkg::CFG_REPORT_MODE:      shadow_cfg.report_mode = cfg_wdata[1:0];
          mre_pkg::CFG_MOTION_REPORTING: shadow_cfg.motion_reporting = cfg_wdata[0];
          mre_pkg::CFG_GRID_COLS:        shadow_cfg.grid_cols = cfg_wdata[8:0];
          mre_pkg::CFG_GRID_ROWS:        shadow_cfg.grid_rows = cfg_wdata[7:0];
          mre_pkg::CFG_OFFSET_X:         shadow_cfg.offset_x = cfg_wdata[3:0];
          mre_pkg::CFG_OFFSET_Y:         shadow_cfg.offset_y = cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (in_accepted) begin
        encode_event('{in_req_type, in_button_number, in_pixel_x, in_pixel_y});
        events_in++;
      end
    end
  end

  always @(negedge clk) begin
    mouse_event_t ev;
    if (!push || in_accepted) begin
      if (rst_n && !hold_input && pending_events.size() != 0 &&
          $urandom_range(99) >= send_gap_pct) begin
        ev = pending_events.pop_front();
        push <= 1'b1;
        in_req_type <= ev.req;
        in_button_number <= ev.btn;
        in_pixel_x <= ev.px;
        in_pixel_y <= ev.py;
      end else begin
        push <= 1'b0;
      end
    end
    pop <= rst_n && ($urandom_range(99) >= pop_stall_pct);
  end

  task automatic write_reg(input logic [mre_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= mre_pkg::CFG_DATA_W'(val);
    @(negedge clk);
    cfg_write_en <= 1'b0;
    reg_writes++;
  endtask

  task automatic program_all(input logic [1:0] mode, input bit motion, input int unsigned cols,
                             input int unsigned rows, input int unsigned ox,
                             input int unsigned oy);
    write_reg(mre_pkg::CFG_REPORT_MODE, mode);
    write_reg(mre_pkg::CFG_MOTION_REPORTING, motion);
    write_reg(mre_pkg::CFG_GRID_COLS, cols);
    write_reg(mre_pkg::CFG_GRID_ROWS, rows);
    write_reg(mre_pkg::CFG_OFFSET_X, ox);
    write_reg(mre_pkg::CFG_OFFSET_Y, oy);
  endtask

  // Returns once every queued event has transferred, every report byte has been
  // checked and the pipeline has had time to finish events that give no report.
  task automatic settle();
    do @(posedge clk);
    while (pending_events.size() != 0 || push || report_bytes_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int start_count;
    logic [1:0] mode;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reporting is off after reset, but the state still follows the events.
    queue_event(mre_pkg::REQ_DOWN, BTN_LEFT, 100, 100);
    queue_event(mre_pkg::REQ_MOTION, BTN_NONE, 300, 300);
    queue_event(mre_pkg::REQ_UP, BTN_LEFT, 300, 300);
    settle();

    write_reg(mre_pkg::CFG_REPORT_MODE, mre_pkg::MODE_X10);
    write_reg(mre_pkg::CFG_MOTION_REPORTING, 1);
    queue_event(mre_pkg::REQ_MOTION, BTN_LEFT, 10, 10);
    queue_event(mre_pkg::REQ_DOWN, BTN_LEFT, 0, 0);
    queue_event(mre_pkg::REQ_MOTION, BTN_NONE, 3, 5);
    queue_event(mre_pkg::REQ_MOTION, BTN_NONE, 7, 15);
    queue_event(mre_pkg::REQ_MOTION, BTN_NONE, PIX_MAX, PIX_MAX);
    queue_event(mre_pkg::REQ_UP, BTN_LEFT, PIX_MAX, PIX_MAX);
    queue_event(mre_pkg::REQ_DOWN, BTN_WHEEL_UP, 8, 16);
    queue_event(mre_pkg::REQ_DOWN, BTN_WHEEL_DOWN, 16, 32);
    queue_event(mre_pkg::REQ_MOTION, BTN_NONE, 40, 40);
    queue_event(mre_pkg::REQ_UP, BTN_WHEEL_UP, 40, 40);
    queue_event(mre_pkg::REQ_DOWN, BTN_NONE, 24, 48);
    queue_event(mre_pkg::REQ_UP, BTN_NONE, 24, 48);
    queue_event(mre_pkg::REQ_DOWN, BTN_BOGUS_7, 50, 60);
    queue_event(mre_pkg::REQ_DOWN, BTN_BOGUS_6, 60, 70);
    queue_event(REQ_RESERVED, BTN_MIDDLE, 60, 70);
    queue_event(mre_pkg::REQ_MOTION, BTN_NONE, 90, 90);
    settle();

    program_all(mre_pkg::MODE_SGR, 0, 511, 255, 15, 31);
    queue_event(mre_pkg::REQ_DOWN, BTN_RIGHT, PIX_MAX, PIX_MAX);
    queue_event(mre_pkg::REQ_MOTION, BTN_NONE, 0, 0);
    queue_event(mre_pkg::REQ_UP, BTN_RIGHT, 0, 0);
    queue_event(mre_pkg::REQ_DOWN, BTN_MIDDLE, 10, 20);
    queue_event(mre_pkg::REQ_UP, BTN_MIDDLE, 10, 20);
    settle();

    write_reg(mre_pkg::CFG_REPORT_MODE, MODE_RESERVED);
    queue_event(mre_pkg::REQ_DOWN, BTN_LEFT, 200, 200);
    queue_event(mre_pkg::REQ_UP, BTN_LEFT, 200, 200);
    settle();

    // Column and row codes above 255 wrap in the byte format.
    write_reg(mre_pkg::CFG_REPORT_MODE, mre_pkg::MODE_X10);
    queue_event(mre_pkg::REQ_DOWN, BTN_LEFT, PIX_MAX, PIX_MAX);
    queue_event(mre_pkg::REQ_UP, BTN_LEFT, PIX_MAX, PIX_MAX);
    settle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin
          send_gap_pct = 0;
          pop_stall_pct = 0;
        end
        1: begin
          send_gap_pct = 57;
          pop_stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          pop_stall_pct = 57;
        end
        default: begin
          send_gap_pct = 32;
          pop_stall_pct = 32;
        end
      endcase
      case (seg)
        0: program_all(mre_pkg::MODE_X10, 1, 5, 5, 15, 31);
        1: program_all(mre_pkg::MODE_SGR, 1, 511, 255, 0, 0);
        2: program_all(mre_pkg::MODE_X10, 1, 511, 255, 0, 0);
        3: program_all(mre_pkg::MODE_SGR, 1, 5, 5, 15, 31);
        default: begin
          case ($urandom_range(9))
            0: mode = mre_pkg::MODE_OFF;
            1: mode = MODE_RESERVED;
            2, 3, 4, 5: mode = mre_pkg::MODE_X10;
            default: mode = mre_pkg::MODE_SGR;
          endcase
          program_all(mode, $urandom_range(3) != 0, $urandom_range(511, 5),
                      $urandom_range(255, 5), $urandom_range(15), $urandom_range(31));
        end
      endcase
      start_count = queued_total;
      while (queued_total - start_count < ITEMS_PER_SEGMENT) gen_gesture();
      if (seg == 1) begin
        while (pending_events.size() > ITEMS_PER_SEGMENT / 2) @(posedge clk);
        hold_input = 1'b1;
        do @(posedge clk);
        while (push || report_bytes_due.size() != 0);
        hold_input = 1'b0;
      end
      settle();
    end

    if (report_bytes_due.size() != 0) begin
      flag_error($sformatf("%0d report bytes never arrived", report_bytes_due.size()));
    end
    $display("Sent %0d mouse events through %0d register writes; %s",
             events_in, reg_writes, "checked report bytes as follows.");
    $display("Checked %0d report bytes in %0d reports; mismatches counted: %0d.",
             bytes_checked, reports_checked, errors);
    if (errors == 0) begin
      $display("mouse_report_encoder_unit_test: done, clean");
    end else begin
      $display("mouse_report_encoder_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d report bytes outstanding.", report_bytes_due.size());
    $display("mouse_report_encoder_unit_test: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mre_pkg.sv
design/mre_front.sv
design/mre_fifo.sv
design/mre_back.sv
design/mouse_report_encoder_unit.sv
tb/sv/mouse_report_encoder_unit_test.sv
